FILE: rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV conversion core.
`timescale 1ns / 1ps

package rgbhsv_pkg;

	localparam int CHAN_W = 8;
	localparam int DIV_BITS = 8;
	localparam int NUM_W = 2 * CHAN_W;

	localparam logic [CHAN_W-1:0] HUE_STEP = 8'd43;
	localparam logic [CHAN_W-1:0] BASE_RED = 8'd0;
	localparam logic [CHAN_W-1:0] BASE_GREEN = 8'd85;
	localparam logic [CHAN_W-1:0] BASE_BLUE = 8'd171;

	typedef struct packed {
		logic [CHAN_W-1:0] base;
		logic              neg;
		logic              grey;
		logic [CHAN_W-1:0] value;
	} rgbhsv_side_t;

	typedef struct packed {
		logic [NUM_W-1:0]  sat_num;
		logic [NUM_W-1:0]  hue_num;
		logic [CHAN_W-1:0] max_ch;
		logic [CHAN_W-1:0] spread;
		rgbhsv_side_t      side;
	} rgbhsv_work_t;

endpackage

FILE: rtl/rgbhsv_front.sv
// Front stage: finds maximum, minimum, sector and division operands of a pixel.
`timescale 1ns / 1ps

module rgbhsv_front
	import rgbhsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  logic              pix_valid,
	output logic              pix_ready,
	output rgbhsv_work_t      work,
	output logic              work_valid,
	input  logic              work_ready
);

	logic              valid_q;
	rgbhsv_work_t      work_q;
	rgbhsv_work_t      work_d;
	logic [CHAN_W-1:0] hi;
	logic [CHAN_W-1:0] lo;
	logic [CHAN_W:0]   diff;
	logic [CHAN_W-1:0] mag;
	logic [NUM_W-1:0]  hue_prod;

	always_comb begin
		if (red >= green && red >= blue) begin
			hi = red;
			work_d.side.base = BASE_RED;
			diff = {1'b0, green} - {1'b0, blue};
		end else if (green >= blue) begin
			hi = green;
			work_d.side.base = BASE_GREEN;
			diff = {1'b0, blue} - {1'b0, red};
		end else begin
			hi = blue;
			work_d.side.base = BASE_BLUE;
			diff = {1'b0, red} - {1'b0, green};
		end
		if (red <= green && red <= blue) begin
			lo = red;
		end else if (green <= blue) begin
			lo = green;
		end else begin
			lo = blue;
		end
		mag = diff[CHAN_W] ? CHAN_W'(~diff + 1'b1) : diff[CHAN_W-1:0];
		hue_prod = NUM_W'(mag) * NUM_W'(HUE_STEP);
		work_d.side.neg = diff[CHAN_W];
		work_d.side.grey = (hi == lo);
		work_d.side.value = hi;
		work_d.max_ch = hi;
		work_d.spread = hi - lo;
		work_d.sat_num = {work_d.spread, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, work_d.spread};
		work_d.hue_num = hue_prod;
	end

	assign pix_ready = !valid_q || work_ready;
	assign work_valid = valid_q;
	assign work = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pix_ready) begin
			valid_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			work_q <= work_d;
		end
	end

endmodule

FILE: rtl/rgbhsv_fifo.sv
// Two-word queue that decouples the front stage from the divider pipeline.
`timescale 1ns / 1ps

module rgbhsv_fifo
	import rgbhsv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rgbhsv_work_t wr_data,
	input  logic         wr_valid,
	output logic         wr_ready,
	output rgbhsv_work_t rd_data,
	output logic         rd_valid,
	input  logic         rd_ready
);

	rgbhsv_work_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, for quotients below 256.
`timescale 1ns / 1ps

module rgbhsv_div
	import rgbhsv_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [CHAN_W-1:0] den,
	output logic [CHAN_W-1:0] quo
);

	logic [CHAN_W-1:0]   rem_s [DIV_BITS];
	logic [CHAN_W-1:0]   low_s [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];
	logic [CHAN_W-1:0]   den_s [DIV_BITS];

	function automatic logic [CHAN_W:0] div_step(
		input logic [CHAN_W-1:0] rem,
		input logic              nbit,
		input logic [CHAN_W-1:0] d
	);
		logic [CHAN_W:0] t;
		logic [CHAN_W:0] r;
		logic            ge;
		t = {rem, nbit};
		ge = (t >= {1'b0, d});
		r = ge ? t - {1'b0, d} : t;
		return {ge, r[CHAN_W-1:0]};
	endfunction

	logic [CHAN_W:0] first;
	assign first = div_step(num[NUM_W-1:CHAN_W], num[CHAN_W-1], den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= first[CHAN_W-1:0];
			quo_s[0] <= {{(DIV_BITS-1){1'b0}}, first[CHAN_W]};
			low_s[0] <= num[CHAN_W-1:0];
			den_s[0] <= den;
		end
	end

	for (genvar k = 1; k < DIV_BITS; k++) begin : g_stage
		logic [CHAN_W:0] nxt;
		assign nxt = div_step(rem_s[k-1], low_s[k-1][CHAN_W-1-k], den_s[k-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= nxt[CHAN_W-1:0];
				quo_s[k] <= {quo_s[k-1][DIV_BITS-2:0], nxt[CHAN_W]};
				low_s[k] <= low_s[k-1];
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign quo = quo_s[DIV_BITS-1];

endmodule

FILE: rtl/rgbhsv_back.sv
// Back part: divider pipeline for saturation and hue, sector fix-up and output register.
`timescale 1ns / 1ps

module rgbhsv_back
	import rgbhsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  rgbhsv_work_t      work,
	input  logic              work_valid,
	output logic              work_ready,
	output logic [CHAN_W-1:0] hue,
	output logic [CHAN_W-1:0] saturation,
	output logic [CHAN_W-1:0] value,
	output logic              hsv_valid,
	input  logic              hsv_ready
);

	logic                advance;
	logic [DIV_BITS-1:0] vld_s;
	rgbhsv_side_t        side_s [DIV_BITS];
	logic [CHAN_W-1:0]   sat_quo;
	logic [CHAN_W-1:0]   hue_quo;
	logic [CHAN_W-1:0]   hue_off;
	logic                valid_q;
	logic [CHAN_W-1:0]   hue_q;
	logic [CHAN_W-1:0]   sat_q;
	logic [CHAN_W-1:0]   value_q;
	rgbhsv_side_t        last;

	assign advance = !valid_q || hsv_ready;
	assign work_ready = advance;

	rgbhsv_div u_sat_div (
		.clk (clk),
		.en  (advance),
		.num (work.sat_num),
		.den (work.max_ch),
		.quo (sat_quo)
	);

	rgbhsv_div u_hue_div (
		.clk (clk),
		.en  (advance),
		.num (work.hue_num),
		.den (work.spread),
		.quo (hue_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			vld_s <= {vld_s[DIV_BITS-2:0], work_valid};
			valid_q <= vld_s[DIV_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s[0] <= work.side;
		end
	end

	for (genvar k = 1; k < DIV_BITS; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (advance) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign last = side_s[DIV_BITS-1];
	assign hue_off = last.neg ? CHAN_W'(~hue_quo + 1'b1) : hue_quo;

	always_ff @(posedge clk) begin
		if (advance) begin
			hue_q <= last.grey ? '0 : CHAN_W'(last.base + hue_off);
			sat_q <= last.grey ? '0 : sat_quo;
			value_q <= last.value;
		end
	end

	assign hsv_valid = valid_q;
	assign hue = hue_q;
	assign saturation = sat_q;
	assign value = value_q;

endmodule

FILE: rtl/rgb_to_hsv_integer_core.sv
// Top level of the 8-bit RGB to HSV conversion core.
`timescale 1ns / 1ps

// While hsv_ready stays high, the core takes one RGB pixel word per clock and
// returns one HSV word per pixel, in order, at one word per clock. Each pixel
// passes through the classification stage, the two-word queue, the pipelined
// restoring dividers (one quotient bit per stage, saturation and hue in parallel)
// and the output register. Black and grey pixels give zero hue and saturation;
// value is always the largest channel.
module rgb_to_hsv_integer_core
	import rgbhsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	output logic [CHAN_W-1:0] hue,
	output logic [CHAN_W-1:0] saturation,
	output logic [CHAN_W-1:0] value,
	output logic              hsv_valid,
	input  logic              hsv_ready
);

	rgbhsv_work_t front_work;
	logic         front_valid;
	logic         front_ready;
	rgbhsv_work_t back_work;
	logic         back_valid;
	logic         back_ready;

	rgbhsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.pix_valid  (pixel_valid),
		.pix_ready  (pixel_ready),
		.work       (front_work),
		.work_valid (front_valid),
		.work_ready (front_ready)
	);

	rgbhsv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (front_work),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_data  (back_work),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	rgbhsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (back_work),
		.work_valid (back_valid),
		.work_ready (back_ready),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready)
	);

endmodule

FILE: rtl/rgbhsv_checker.sv
// Port-level assertions for the RGB to HSV core, bound to its top level.
`timescale 1ns / 1ps

module rgbhsv_checker
	import rgbhsv_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_valid,
	input logic              pixel_ready,
	input logic [CHAN_W-1:0] hue,
	input logic [CHAN_W-1:0] saturation,
	input logic [CHAN_W-1:0] value,
	input logic              hsv_valid,
	input logic              hsv_ready
);

	localparam logic [3:0] MAX_INFLIGHT = 4'd12;

	logic [3:0] inflight_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in = pixel_valid && pixel_ready;
	assign acc_out = hsv_valid && hsv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + 4'd1;
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - 4'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue) && $stable(saturation)
			&& $stable(value))
		else $error("Stalled HSV word changed or was dropped.");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> inflight_q != 4'd0)
		else $error("HSV word shown with no pixel outstanding.");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= MAX_INFLIGHT)
		else $error("More pixels outstanding than the core can hold.");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation == '0 |-> hue == '0)
		else $error("Zero saturation with nonzero hue.");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && value == '0 |-> saturation == '0)
		else $error("Black pixel with nonzero saturation.");

endmodule

bind rgb_to_hsv_integer_core rgbhsv_checker u_rgbhsv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_ready (pixel_ready),
	.hue         (hue),
	.saturation  (saturation),
	.value       (value),
	.hsv_valid   (hsv_valid),
	.hsv_ready   (hsv_ready)
);
